[hw/rtl/soq_pkg.sv]
`timescale 1ns / 1ps
// Package with sizes, action codes and status codes of the searchable ordered queue.
package soq_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int CMP_W   = CNT_W + 1;
	localparam int DATA_W  = 32;
	localparam int OCNT_W  = 5;

	typedef enum logic [1:0] {
		ACT_APPEND  = 2'd0,
		ACT_SEARCH  = 2'd1,
		ACT_REPLACE = 2'd2,
		ACT_REMOVE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

endpackage

[hw/rtl/soq_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module soq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/searchable_ordered_queue.sv]
`timescale 1ns / 1ps
// Top level of the searchable ordered queue: list control and the entry memory.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------
//   request | req_valid, req_stall | action, key_value, replacement
//   result  | rsp_valid, rsp_stall | hit, status, entry_count
//
// An append goes straight to its result. A search, replace or remove scans the entries
// from position 0, one memory read per scanned entry, until a match or the last entry.
// A remove that hits then moves every later entry up by one position in the memory.
// Reset empties the list at once; no clearing pass.
// A result waits in the output register while rsp_stall is high; the next word is
// accepted meanwhile and its result is held until the output register is free.
module searchable_ordered_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         action,
	input  logic signed [31:0] key_value,
	input  logic signed [31:0] replacement,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic               hit,
	output logic [1:0]         status,
	output logic [4:0]         entry_count
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_RESP
	} state_t;

	state_t                       state_q;
	soq_pkg::action_t             act_q;
	logic [soq_pkg::DATA_W-1:0]   key_q;
	logic [soq_pkg::DATA_W-1:0]   repl_q;
	logic [soq_pkg::IDX_W-1:0]    idx_q;
	logic [soq_pkg::CNT_W-1:0]    count_q;
	logic                         res_hit_q;
	soq_pkg::status_t             res_status_q;
	logic                         rsp_valid_q;
	logic                         hit_q;
	soq_pkg::status_t             status_q;
	logic [soq_pkg::OCNT_W-1:0]   entry_count_q;

	logic                         ram_we;
	logic [soq_pkg::IDX_W-1:0]    ram_waddr;
	logic [soq_pkg::DATA_W-1:0]   ram_wdata;
	logic [soq_pkg::IDX_W-1:0]    ram_raddr;
	logic [soq_pkg::DATA_W-1:0]   ram_rdata;

	logic                         full;
	logic                         match;
	logic                         more;
	logic                         more2;
	logic [soq_pkg::IDX_W-1:0]    idx_p1;
	logic [soq_pkg::IDX_W-1:0]    idx_p2;
	logic                         rsp_free;

	assign full     = (count_q == soq_pkg::CNT_W'(soq_pkg::DEPTH));
	assign match    = (ram_rdata == key_q);
	assign more     = (soq_pkg::CMP_W'(idx_q) + soq_pkg::CMP_W'(1)) < soq_pkg::CMP_W'(count_q);
	assign more2    = (soq_pkg::CMP_W'(idx_q) + soq_pkg::CMP_W'(2)) < soq_pkg::CMP_W'(count_q);
	assign idx_p1   = idx_q + soq_pkg::IDX_W'(1);
	assign idx_p2   = idx_q + soq_pkg::IDX_W'(2);
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	assign req_stall   = (state_q != S_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign hit         = hit_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = soq_pkg::IDX_W'(count_q);
		ram_wdata = key_value;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid && soq_pkg::action_t'(action) == soq_pkg::ACT_APPEND) begin
					ram_we = !full;
				end
			end
			S_SCAN: begin
				ram_raddr = idx_p1;
				if (match && act_q == soq_pkg::ACT_REPLACE) begin
					ram_we    = 1'b1;
					ram_waddr = idx_q;
					ram_wdata = repl_q;
				end
			end
			S_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = ram_rdata;
				ram_raddr = idx_p2;
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			act_q         <= soq_pkg::ACT_APPEND;
			key_q         <= '0;
			repl_q        <= '0;
			idx_q         <= '0;
			count_q       <= '0;
			res_hit_q     <= 1'b0;
			res_status_q  <= soq_pkg::ST_OK;
			rsp_valid_q   <= 1'b0;
			hit_q         <= 1'b0;
			status_q      <= soq_pkg::ST_OK;
			entry_count_q <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_RESP) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						act_q  <= soq_pkg::action_t'(action);
						key_q  <= key_value;
						repl_q <= replacement;
						idx_q  <= '0;
						res_hit_q <= 1'b0;
						if (soq_pkg::action_t'(action) == soq_pkg::ACT_APPEND) begin
							if (full) begin
								res_status_q <= soq_pkg::ST_FULL;
							end else begin
								res_status_q <= soq_pkg::ST_OK;
								count_q      <= count_q + soq_pkg::CNT_W'(1);
							end
							state_q <= S_RESP;
						end else if (count_q == '0) begin
							res_status_q <= soq_pkg::ST_EMPTY;
							state_q      <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (match) begin
						res_hit_q    <= 1'b1;
						res_status_q <= soq_pkg::ST_OK;
						if (act_q == soq_pkg::ACT_REMOVE && more) begin
							state_q <= S_SHIFT;
						end else begin
							if (act_q == soq_pkg::ACT_REMOVE) begin
								count_q <= count_q - soq_pkg::CNT_W'(1);
							end
							state_q <= S_RESP;
						end
					end else if (more) begin
						idx_q <= idx_p1;
					end else begin
						res_hit_q    <= 1'b0;
						res_status_q <= soq_pkg::ST_NOT_FOUND;
						state_q      <= S_RESP;
					end
				end
				S_SHIFT: begin
					if (more2) begin
						idx_q <= idx_p1;
					end else begin
						count_q <= count_q - soq_pkg::CNT_W'(1);
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp_free) begin
						rsp_valid_q   <= 1'b1;
						hit_q         <= res_hit_q;
						status_q      <= res_status_q;
						entry_count_q <= soq_pkg::OCNT_W'(count_q);
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	soq_ram #(
		.WIDTH(soq_pkg::DATA_W),
		.DEPTH(soq_pkg::DEPTH)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule
